@@ hw/rtl/mmpid_pkg.sv @@
// Package for the multi-motor PID speed loop: field widths, register codes,
// configuration struct and direction codes. No dependencies.
`default_nettype none

package mmpid_pkg;

  // Item field widths
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned DIR_W   = 2;
  localparam int unsigned SPEED_W = 23;
  localparam int unsigned MEAS_W  = 24;
  localparam int unsigned ERR_W   = 25;
  localparam int unsigned PULSE_W = 16;

  // Configuration register widths
  localparam int unsigned GAIN_W        = 16;
  localparam int unsigned GAINS_W       = 3 * GAIN_W;
  localparam int unsigned NUM_GAIN_REGS = 4;
  localparam int unsigned LIMIT_W       = 16;
  localparam int unsigned SEL_W         = 4;

  // Gain fields inside one packed gains register
  localparam int unsigned KP_LSB = 0;
  localparam int unsigned KI_LSB = GAIN_W;
  localparam int unsigned KD_LSB = 2 * GAIN_W;

  // APB port: 64-bit data, registers on 8-byte strides
  localparam int unsigned PADDR_W   = 6;
  localparam int unsigned PDATA_W   = 64;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned REG_LSB   = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAINS_0   = 3'd0,
    REG_GAINS_1   = 3'd1,
    REG_GAINS_2   = 3'd2,
    REG_GAINS_3   = 3'd3,
    REG_LIMIT_A   = 3'd4,
    REG_LIMIT_B   = 3'd5,
    REG_LIMIT_SEL = 3'd6,
    REG_DEAD_ZONE = 3'd7
  } reg_idx_e;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1000;
  localparam logic [SEL_W-1:0]   SEL_RESET   = 4'hF;

  // Drive direction codes (2-bit signed)
  localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sb00;
  localparam logic signed [DIR_W-1:0] DIR_FWD  = 2'sb01;
  localparam logic signed [DIR_W-1:0] DIR_REV  = 2'sb11;

  typedef struct packed {
    logic [NUM_GAIN_REGS-1:0][GAINS_W-1:0] gains;
    logic [LIMIT_W-1:0]                    limit_a;
    logic [LIMIT_W-1:0]                    limit_b;
    logic [SEL_W-1:0]                      limit_sel;
    logic [LIMIT_W-1:0]                    dead_zone;
  } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/mmpid_if.sv @@
// Item channel interfaces for the multi-motor PID speed loop (tick in, drive out).
// Depends on mmpid_pkg for field widths.
`default_nettype none

interface mmpid_in_if import mmpid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         motor_index;
  logic signed [DIR_W-1:0]  command_direction;
  logic [SPEED_W-1:0]       command_speed;
  logic signed [MEAS_W-1:0] measured_speed;

  modport source (output valid, motor_index, command_direction, command_speed,
                  measured_speed, input ready);
  modport sink   (input valid, motor_index, command_direction, command_speed,
                  measured_speed, output ready);
endinterface

interface mmpid_out_if import mmpid_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        motor_number;
  logic signed [DIR_W-1:0] drive_direction;
  logic [PULSE_W-1:0]      drive_pulse;

  modport source (output valid, motor_number, drive_direction, drive_pulse,
                  input ready);
  modport sink   (input valid, motor_number, drive_direction, drive_pulse,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mmpid_ram.sv @@
// Generic single-clock RAM, one write port and one read port, registered read.
// No dependencies.
`default_nettype none

module mmpid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mmpid_cfg.sv @@
// APB register file for the PID speed loop: gains, limits, limit select, dead zone.
// Depends on mmpid_pkg (cfg_t, reg_idx_e, widths).
`default_nettype none

module mmpid_cfg import mmpid_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_e'(paddr[REG_LSB +: REG_IDX_W]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gains     <= '0;
      cfg_q.limit_a   <= LIMIT_RESET;
      cfg_q.limit_b   <= LIMIT_RESET;
      cfg_q.limit_sel <= SEL_RESET;
      cfg_q.dead_zone <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GAINS_0:   cfg_q.gains[0]  <= pwdata[GAINS_W-1:0];
        REG_GAINS_1:   cfg_q.gains[1]  <= pwdata[GAINS_W-1:0];
        REG_GAINS_2:   cfg_q.gains[2]  <= pwdata[GAINS_W-1:0];
        REG_GAINS_3:   cfg_q.gains[3]  <= pwdata[GAINS_W-1:0];
        REG_LIMIT_A:   cfg_q.limit_a   <= pwdata[LIMIT_W-1:0];
        REG_LIMIT_B:   cfg_q.limit_b   <= pwdata[LIMIT_W-1:0];
        REG_LIMIT_SEL: cfg_q.limit_sel <= pwdata[SEL_W-1:0];
        REG_DEAD_ZONE: cfg_q.dead_zone <= pwdata[LIMIT_W-1:0];
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_GAINS_0:   prdata = PDATA_W'(cfg_q.gains[0]);
      REG_GAINS_1:   prdata = PDATA_W'(cfg_q.gains[1]);
      REG_GAINS_2:   prdata = PDATA_W'(cfg_q.gains[2]);
      REG_GAINS_3:   prdata = PDATA_W'(cfg_q.gains[3]);
      REG_LIMIT_A:   prdata = PDATA_W'(cfg_q.limit_a);
      REG_LIMIT_B:   prdata = PDATA_W'(cfg_q.limit_b);
      REG_LIMIT_SEL: prdata = PDATA_W'(cfg_q.limit_sel);
      REG_DEAD_ZONE: prdata = PDATA_W'(cfg_q.dead_zone);
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/mmpid_core.sv @@
// PID sequencer and datapath: reads per-motor state from the state RAM, updates it,
// writes it back and forms the drive result. Depends on mmpid_pkg, mmpid_if, mmpid_ram.
`default_nettype none

module mmpid_core import mmpid_pkg::*; #(
  parameter int MOTOR_COUNT     = 4,
  parameter int CONTROL_RATE_HZ = 1000,
  parameter int FRACTION_BITS   = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  mmpid_in_if.sink    in_i,
  mmpid_out_if.source out_o
);

  localparam int F    = FRACTION_BITS;
  localparam int SS   = F + 8;                      // fraction bits of the PID sum
  localparam int AW   = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int IW   = LIMIT_W + F + 1;            // integral spans +/- limit << F
  localparam int MEM_W = ERR_W + IW;
  localparam int DD_W = ERR_W + 1;                  // error difference
  localparam int RW   = $clog2(CONTROL_RATE_HZ + 1);
  localparam int DRW  = DD_W + RW;                  // difference times rate
  localparam int LO_W = DRW / 2;
  localparam int HI_W = DRW - LO_W;

  // error / rate by reciprocal: exact for |err| < 2^DIVN
  localparam int DIVN    = ERR_W;
  localparam int DIVL    = $clog2(CONTROL_RATE_HZ);
  localparam longint unsigned RECIP =
      ((64'd1 << (DIVN + DIVL)) + 64'(CONTROL_RATE_HZ) - 64'd1) / 64'(CONTROL_RATE_HZ);
  localparam int RECIP_W = DIVN + 1;
  localparam int QP_W    = DIVN + RECIP_W;
  localparam int QI_W    = ((IW > ERR_W) ? IW : ERR_W) + 2;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
  localparam logic [DRW-1:0]     RATE_C  = DRW'(CONTROL_RATE_HZ);

  // sum width covers all three terms plus the dead-zone offset
  localparam int PT_W  = GAIN_W + ERR_W;
  localparam int IT_W  = GAIN_W + IW;
  localparam int DL_W  = GAIN_W + LO_W + 1;
  localparam int DH_W  = GAIN_W + HI_W;
  localparam int TM_A  = (PT_W > IT_W) ? PT_W : IT_W;
  localparam int TM_B  = (TM_A > GAIN_W + DRW) ? TM_A : GAIN_W + DRW;
  localparam int TM_C  = (TM_B > LIMIT_W + SS + 1) ? TM_B : LIMIT_W + SS + 1;
  localparam int SW    = TM_C + 3;
  localparam int MAG_W = SW - SS;
  localparam longint unsigned NZ = (64'd1 << SS) / 64'd1000;   // |sum| > 0.001

  localparam logic signed [ERR_W-1:0] ONE_RPM = ERR_W'(64'd1 << F);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_LOAD  = 8'b0000_0010,
    ST_INTEG = 8'b0000_0100,
    ST_WRITE = 8'b0000_1000,
    ST_DHI   = 8'b0001_0000,
    ST_SUM   = 8'b0010_0000,
    ST_DEAD  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // control
  logic [MOTOR_COUNT-1:0] valid_q, valid_d;
  logic                   out_valid_q, out_valid_d;
  logic                   accept, motor_ok, out_load;

  // payload registers
  logic [IDX_W-1:0]         motor_q;
  logic signed [ERR_W-1:0]  err_q;
  logic                     tzero_q;
  logic signed [IW-1:0]     integ_old_q, integ_q;
  logic signed [DD_W-1:0]   dd_q;
  logic [QP_W-1:0]          qprod_q;
  logic signed [PT_W-1:0]   pterm_q;
  logic signed [DRW-1:0]    dr_q;
  logic signed [IT_W-1:0]   iterm_q;
  logic signed [DL_W-1:0]   dlo_q;
  logic signed [DH_W-1:0]   dhi_q;
  logic signed [SW-1:0]     psum_q, sum_q, sum2_q;
  logic signed [DIR_W-1:0]  dir_q;
  logic [IDX_W-1:0]         out_motor_q;
  logic signed [DIR_W-1:0]  out_dir_q;
  logic [PULSE_W-1:0]       out_pulse_q;

  // combinational
  logic [AW-1:0]            in_addr, addr;
  logic [MEM_W-1:0]         rdata, entry;
  logic signed [ERR_W-1:0]  prev;
  logic signed [MEAS_W-1:0] speed_s, target;
  logic signed [ERR_W-1:0]  err_d;
  logic [ERR_W-1:0]         errmag;
  logic [LIMIT_W-1:0]       cur_limit;
  logic signed [GAIN_W-1:0] kp, ki, kd;
  logic [QI_W-1:0]          qmag;
  logic signed [QI_W-1:0]   qs, isum, limq;
  logic signed [IW-1:0]     integ_d;
  logic signed [SW-1:0]     dz_sh, nz_s, dterm;
  logic                     sum_pos, sum_neg;
  logic [SW-1:0]            sum_abs;
  logic [MAG_W-1:0]         mag;
  logic [PULSE_W-1:0]       pulse;

  assign accept   = in_i.valid & in_i.ready;
  assign motor_ok = 32'(in_i.motor_index) < MOTOR_COUNT;
  assign in_addr  = AW'(in_i.motor_index);
  assign addr     = AW'(motor_q);
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_load = (state_q == ST_OUT) & (~out_valid_q | out_o.ready);

  // Per-motor state: {previous error, integral}. Read at acceptance, written back
  // in ST_WRITE after ST_LOAD and ST_INTEG; the next read comes only after that, so no forwarding.
  mmpid_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MOTOR_COUNT)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_WRITE),
    .waddr_i (addr),
    .wdata_i ({err_q, integ_q}),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (rdata)
  );

  // Entries not written since reset read as zero
  assign entry = valid_q[addr] ? rdata : '0;
  assign prev  = signed'(entry[MEM_W-1:IW]);

  // Target and error at acceptance
  always_comb begin
    speed_s = signed'(MEAS_W'(in_i.command_speed));
    priority if (in_i.command_direction == DIR_NONE) begin
      target = '0;
    end else if (in_i.command_direction[DIR_W-1]) begin
      target = -speed_s;
    end else begin
      target = speed_s;
    end
    err_d = ERR_W'(target) - ERR_W'(in_i.measured_speed);
  end

  // Config selections for the current motor
  assign cur_limit = cfg_i.limit_sel[motor_q] ? cfg_i.limit_a : cfg_i.limit_b;
  assign kp = signed'(cfg_i.gains[motor_q][KP_LSB +: GAIN_W]);
  assign ki = signed'(cfg_i.gains[motor_q][KI_LSB +: GAIN_W]);
  assign kd = signed'(cfg_i.gains[motor_q][KD_LSB +: GAIN_W]);

  assign errmag = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);

  // Integral update: add error / rate (toward zero), clamp, clear near stop
  always_comb begin
    qmag = QI_W'(qprod_q >> (DIVN + DIVL));
    qs   = err_q[ERR_W-1] ? -signed'(qmag) : signed'(qmag);
    isum = QI_W'(integ_old_q) + qs;
    limq = signed'(QI_W'({cur_limit, {F{1'b0}}}));
    priority if (tzero_q && err_q < ONE_RPM && err_q > -ONE_RPM) begin
      integ_d = '0;
    end else if (isum > limq) begin
      integ_d = IW'(limq);
    end else if (isum < -limq) begin
      integ_d = IW'(-limq);
    end else begin
      integ_d = IW'(isum);
    end
  end

  // Derivative term reassembled from its two partial products
  assign dterm = (SW'(dhi_q) <<< LO_W) + SW'(dlo_q);

  // Dead zone and direction
  assign dz_sh   = signed'(SW'(cfg_i.dead_zone) << SS);
  assign nz_s    = signed'(SW'(NZ));
  assign sum_pos = sum_q > nz_s;
  assign sum_neg = sum_q < -nz_s;

  // Pulse magnitude saturated at the motor's limit
  always_comb begin
    sum_abs = sum2_q[SW-1] ? SW'(-sum2_q) : SW'(sum2_q);
    mag     = MAG_W'(sum_abs >> SS);
    if (dir_q == DIR_NONE) begin
      pulse = '0;
    end else if (mag > MAG_W'(cur_limit)) begin
      pulse = cur_limit;
    end else begin
      pulse = PULSE_W'(mag);
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept && motor_ok) state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_INTEG;
      ST_INTEG: state_d = ST_WRITE;
      ST_WRITE: state_d = ST_DHI;
      ST_DHI:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_DEAD;
      ST_DEAD:  state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (state_q == ST_WRITE) begin
      valid_d[addr] = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers, one step per state
  always_ff @(posedge clk_i) begin
    if (accept) begin
      motor_q <= in_i.motor_index;
      err_q   <= err_d;
      tzero_q <= (in_i.command_direction == DIR_NONE) || (in_i.command_speed == '0);
    end
    if (state_q == ST_LOAD) begin
      integ_old_q <= signed'(entry[IW-1:0]);
      dd_q        <= DD_W'(err_q) - DD_W'(prev);
      qprod_q     <= QP_W'(errmag) * QP_W'(RECIP_C);
      pterm_q     <= PT_W'(kp) * PT_W'(err_q);
    end
    if (state_q == ST_INTEG) begin
      integ_q <= integ_d;
      dr_q    <= DRW'(dd_q) * signed'(RATE_C);
    end
    if (state_q == ST_WRITE) begin
      iterm_q <= IT_W'(ki) * IT_W'(integ_q);
      dlo_q   <= DL_W'(kd) * signed'(DL_W'(dr_q[LO_W-1:0]));
    end
    if (state_q == ST_DHI) begin
      dhi_q  <= DH_W'(kd) * DH_W'(signed'(dr_q[DRW-1:LO_W]));
      psum_q <= SW'(pterm_q) + SW'(iterm_q);
    end
    if (state_q == ST_SUM) begin
      sum_q <= psum_q + dterm;
    end
    if (state_q == ST_DEAD) begin
      priority if (sum_pos) begin
        sum2_q <= sum_q + dz_sh;
        dir_q  <= DIR_FWD;
      end else if (sum_neg) begin
        sum2_q <= sum_q - dz_sh;
        dir_q  <= DIR_REV;
      end else begin
        sum2_q <= sum_q;
        dir_q  <= DIR_NONE;
      end
    end
    if (out_load) begin
      out_motor_q <= motor_q;
      out_dir_q   <= dir_q;
      out_pulse_q <= pulse;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.motor_number    = out_motor_q;
  assign out_o.drive_direction = out_dir_q;
  assign out_o.drive_pulse     = out_pulse_q;

endmodule

`default_nettype wire

@@ hw/rtl/multi_motor_pid_speed_loop.sv @@
// Top level of the multi-motor PID speed loop: APB register file plus PID core.
// Depends on mmpid_pkg, mmpid_if, mmpid_cfg, mmpid_core (and mmpid_ram below it).
//
//   channel   direction  handshake            payload
//   in_i      in         valid/ready          motor_index, command_direction,
//                                             command_speed, measured_speed
//   out_o     out        valid/ready          motor_number, drive_direction, drive_pulse
//   APB       in         psel/penable/pwrite  paddr (8-byte stride), pwdata, prdata
//
// An item steps from acceptance through the sequencer states LOAD, INTEG, WRITE, DHI,
// SUM, DEAD and OUT around the state RAM read-write before the result register loads;
// a new item enters only once the sequencer is back in IDLE.
// One item is worked at a time; the next is accepted the cycle after the result
// register loads, even while that result still waits for out_o.ready.
// A tick for a motor index at or above MOTOR_COUNT is taken and dropped.
// Reset clears the config to its reset values and the per-motor state to zero.
`default_nettype none

module multi_motor_pid_speed_loop import mmpid_pkg::*; #(
  parameter int MOTOR_COUNT     = 4,
  parameter int CONTROL_RATE_HZ = 1000,
  parameter int FRACTION_BITS   = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  mmpid_in_if.sink                in_i,
  mmpid_out_if.source             out_o
);

  cfg_t cfg;

  mmpid_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mmpid_core #(
    .MOTOR_COUNT     (MOTOR_COUNT),
    .CONTROL_RATE_HZ (CONTROL_RATE_HZ),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
